// ----- src/imubias_pkg.sv -----
// Shared types, constants and state codes for the IMU bias mean estimator.
package imubias_pkg;

    localparam int IMUBIAS_MAX_SAMPLES = 300;
    localparam int IMUBIAS_FRAC_BITS   = 8;
    localparam int SAMPLE_W            = 16;
    localparam int BIAS_W              = 24;
    localparam int COUNT_W             = 9;
    localparam int ACCEL_ONE_G_LOG2    = 12;
    localparam int NUM_CHAN            = 6;
    localparam int NUM_ACCEL           = 3;
    localparam int CFG_ADDR_W          = 3;
    localparam int CFG_DATA_W          = 32;

    // Register index decode, taken from the word address bit.
    localparam logic REG_SAMPLE_COUNT = 1'b0;
    localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET = COUNT_W'(300);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
        logic signed [SAMPLE_W-1:0] gyro_x;
        logic signed [SAMPLE_W-1:0] gyro_y;
        logic signed [SAMPLE_W-1:0] gyro_z;
        logic                       accel_ok;
        logic                       gyro_ok;
    } t_imu_sample;

    typedef struct packed {
        logic signed [BIAS_W-1:0] accel_bias_x;
        logic signed [BIAS_W-1:0] accel_bias_y;
        logic signed [BIAS_W-1:0] accel_bias_z;
        logic signed [BIAS_W-1:0] gyro_bias_x;
        logic signed [BIAS_W-1:0] gyro_bias_y;
        logic signed [BIAS_W-1:0] gyro_bias_z;
        logic [COUNT_W-1:0]       valid_count;
        logic                     success;
        logic                     magnitude_warning;
    } t_bias_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FINISH,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_OUT
    } t_state;

endpackage

// ----- src/imubias_div.sv -----
// Serial restoring divider: signed dividend by unsigned count, truncating toward zero.
module imubias_div #(
    parameter int MW = 24,
    parameter int CW = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [MW:0]  i_dividend,
    input  logic [CW-1:0]       i_divisor,
    output logic                o_done,
    output logic signed [MW:0]  o_quotient
);

    localparam int STEP_W = $clog2(MW);

    logic                r_busy;
    logic                r_done;
    logic                r_neg;
    logic [CW-1:0]       r_divisor;
    logic [CW-1:0]       r_rem;
    logic [MW-1:0]       r_quo;
    logic [STEP_W-1:0]   r_step;
    logic signed [MW:0]  r_q;

    logic [MW:0]         mag;
    logic [CW:0]         trial;
    logic [CW:0]         diff;
    logic                ge;
    logic [CW-1:0]       n_rem;
    logic [MW-1:0]       n_quo;

    always_comb begin
        mag   = i_dividend[MW] ? (MW+1)'(-i_dividend) : i_dividend;
        trial = {r_rem, r_quo[MW-1]};
        diff  = trial - {1'b0, r_divisor};
        ge    = !diff[CW];
        n_rem = ge ? diff[CW-1:0] : trial[CW-1:0];
        n_quo = {r_quo[MW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == STEP_W'(MW-1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg     <= i_dividend[MW];
            r_divisor <= i_divisor;
            r_rem     <= '0;
            r_quo     <= mag[MW-1:0];
            r_step    <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_step <= r_step + STEP_W'(1);
            if (r_step == STEP_W'(MW-1)) begin
                // apply the sign on the last step
                r_q <= r_neg ? -$signed({1'b0, n_quo}) : $signed({1'b0, n_quo});
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ----- src/imubias_sq.sv -----
// Sum of squares of the accel means and the magnitude window check.
module imubias_sq #(
    parameter int MW = 24,
    parameter int FRAC_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [MW-1:0] i_accel [imubias_pkg::NUM_ACCEL],
    output logic                o_done,
    output logic                o_warn
);
    import imubias_pkg::*;

    localparam int          G2_LOG = 2 * (ACCEL_ONE_G_LOG2 + FRAC_BITS);
    localparam logic [63:0] G2     = 64'd1 << G2_LOG;
    localparam logic [63:0] HI_LIM = (64'd169 * G2) / 64'd100;
    localparam logic [63:0] LO_LIM = (64'd49 * G2 + 64'd99) / 64'd100;

    logic                  r_busy;
    logic                  r_done;
    logic [1:0]            r_cyc;
    logic [2*MW-1:0]       r_prod;
    logic [2*MW-1:0]       r_acc;

    logic signed [MW-1:0]  operand;
    logic signed [2*MW-1:0] square;
    logic [63:0]           acc_ext;

    always_comb begin
        operand = '0;
        for (int k = 0; k < NUM_ACCEL; k++) begin
            if (r_cyc == 2'(k)) begin
                operand = i_accel[k];
            end
        end
        square  = operand * operand;
        acc_ext = 64'(r_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cyc  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cyc  <= '0;
            end else if (r_busy) begin
                r_cyc <= r_cyc + 2'd1;
                if (r_cyc == 2'(NUM_ACCEL)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // multiply one axis per cycle, accumulate the previous product
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cyc != 2'(NUM_ACCEL)) begin
                r_prod <= unsigned'(square);
            end
            if (r_cyc != 2'd0) begin
                r_acc <= r_acc + r_prod;
            end
        end
    end

    assign o_done = r_done;
    assign o_warn = (acc_ext > HI_LIM) || (acc_ext < LO_LIM);

endmodule

// ----- src/imu_bias_welford_mean.sv -----
// Top level of the IMU bias estimator: Welford running means over a run of samples.
//
//  channel   direction  handshake                 beat payload
//  -------   ---------  ------------------------  -----------------------------
//  sample    in         i_in_valid / o_in_ready   i_in_data  (t_imu_sample)
//  result    out        o_out_valid / i_out_ready o_out_data (t_bias_result)
//  config    in         psel/penable/pwrite/...   sample_count at byte 0
//
//  A sample beat with both ok flags is paced by the one serial divider that is
//  shared by all six channels, one quotient bit per cycle; MW = 16 +
//  MEAN_FRACTION_BITS is the mean width. A sample with a flag clear skips the
//  divider. The last beat of a run adds the three squares through the shared multiplier.
//  Reset clears the means, both counters and the output valid flag and loads
//  sample_count with 300. The result register holds while i_out_ready is low;
//  the next sample is taken meanwhile, and only a second finished run waits.
module imu_bias_welford_mean #(
    parameter int MAX_SAMPLES        = imubias_pkg::IMUBIAS_MAX_SAMPLES,
    parameter int MEAN_FRACTION_BITS = imubias_pkg::IMUBIAS_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  imubias_pkg::t_imu_sample             i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output imubias_pkg::t_bias_result            o_out_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [imubias_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [imubias_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [imubias_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                 pready
);
    import imubias_pkg::*;

    // mean width: sample bits plus fraction bits; means never leave the
    // range of the scaled samples, so this holds them exactly
    localparam int MW   = SAMPLE_W + MEAN_FRACTION_BITS;
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int EW   = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int CH_W = $clog2(NUM_CHAN);

    t_state                r_state;
    t_state                n_state;
    logic [COUNT_W-1:0]    r_cfg;
    t_imu_sample           r_samp;
    logic signed [MW-1:0]  r_mean [NUM_CHAN];
    logic [CW-1:0]         r_valid_cnt;
    logic [CW-1:0]         r_sample_cnt;
    logic [CH_W-1:0]       r_ch;
    logic                  r_warn;
    logic                  r_out_valid;
    t_bias_result          r_out_data;

    logic                  in_fire;
    logic                  in_good;
    logic                  cfg_wr;
    logic                  div_start;
    logic                  div_done;
    logic signed [MW:0]    div_q;
    logic                  sq_start;
    logic                  sq_done;
    logic                  sq_warn;
    logic                  mean_we;
    logic                  load_out;
    logic                  run_end;
    logic [EW-1:0]         cfg_ext;
    logic [EW-1:0]         eff_count;
    logic signed [SAMPLE_W-1:0] samp_ch;
    logic signed [MW-1:0]  x_scaled;
    logic signed [MW:0]    delta;
    logic signed [MW-1:0]  n_mean;
    logic signed [MW-1:0]  accel_means [NUM_ACCEL];
    logic                  success;

    assign in_fire    = i_in_valid && o_in_ready;
    assign in_good    = i_in_data.accel_ok && i_in_data.gyro_ok;
    assign o_in_ready = (r_state == ST_IDLE);

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SAMPLE_COUNT);
    assign prdata = (paddr[2] == REG_SAMPLE_COUNT) ? CFG_DATA_W'(r_cfg) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= SAMPLE_COUNT_RESET;
        end else if (cfg_wr) begin
            r_cfg <= pwdata[COUNT_W-1:0];
        end
    end

    // zero acts as one, anything above the cap acts as the cap
    always_comb begin
        cfg_ext = EW'(r_cfg);
        if (r_cfg == '0) begin
            eff_count = EW'(1);
        end else if (cfg_ext > EW'(MAX_SAMPLES)) begin
            eff_count = EW'(MAX_SAMPLES);
        end else begin
            eff_count = cfg_ext;
        end
        run_end = EW'(r_sample_cnt) >= eff_count;
    end

    // ---------------- channel datapath ----------------
    always_comb begin
        case (r_ch)
            CH_W'(0): samp_ch = r_samp.accel_x;
            CH_W'(1): samp_ch = r_samp.accel_y;
            CH_W'(2): samp_ch = r_samp.accel_z;
            CH_W'(3): samp_ch = r_samp.gyro_x;
            CH_W'(4): samp_ch = r_samp.gyro_y;
            default:  samp_ch = r_samp.gyro_z;
        endcase
        x_scaled = MW'(samp_ch) <<< MEAN_FRACTION_BITS;
        delta    = (MW+1)'(x_scaled) - (MW+1)'(r_mean[r_ch]);
        n_mean   = MW'((MW+1)'(r_mean[r_ch]) + div_q);
        for (int k = 0; k < NUM_ACCEL; k++) begin
            accel_means[k] = r_mean[k];
        end
    end

    imubias_div #(
        .MW (MW),
        .CW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (delta),
        .i_divisor  (r_valid_cnt),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    imubias_sq #(
        .MW        (MW),
        .FRAC_BITS (MEAN_FRACTION_BITS)
    ) u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_accel (accel_means),
        .o_done  (sq_done),
        .o_warn  (sq_warn)
    );

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        sq_start  = 1'b0;
        mean_we   = 1'b0;
        load_out  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = in_good ? ST_DIV_GO : ST_FINISH;
                end
            end
            ST_DIV_GO: begin
                div_start = 1'b1;
                n_state   = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    mean_we = 1'b1;
                    n_state = (r_ch == CH_W'(NUM_CHAN - 1)) ? ST_FINISH : ST_DIV_GO;
                end
            end
            ST_FINISH: begin
                n_state = run_end ? ST_SQ_GO : ST_IDLE;
            end
            ST_SQ_GO: begin
                sq_start = 1'b1;
                n_state  = ST_SQ_WAIT;
            end
            ST_SQ_WAIT: begin
                if (sq_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold until the result register is free or drains this cycle
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------- run state: means and counters ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHAN; k++) begin
                r_mean[k] <= '0;
            end
            r_valid_cnt  <= '0;
            r_sample_cnt <= '0;
            r_ch         <= '0;
        end else begin
            if (in_fire) begin
                r_sample_cnt <= r_sample_cnt + CW'(1);
                if (in_good) begin
                    r_valid_cnt <= r_valid_cnt + CW'(1);
                end
                r_ch <= '0;
            end
            if (mean_we) begin
                r_mean[r_ch] <= n_mean;
                r_ch         <= r_ch + CH_W'(1);
            end
            if (load_out) begin
                // clear for the next run
                for (int k = 0; k < NUM_CHAN; k++) begin
                    r_mean[k] <= '0;
                end
                r_valid_cnt  <= '0;
                r_sample_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_samp <= i_in_data;
        end
        if (r_state == ST_SQ_WAIT && sq_done) begin
            r_warn <= sq_warn;
        end
    end

    // ---------------- result register ----------------
    assign success = {r_valid_cnt, 1'b0} >= {1'b0, r_sample_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data.accel_bias_x      <= BIAS_W'(r_mean[0]);
            r_out_data.accel_bias_y      <= BIAS_W'(r_mean[1]);
            r_out_data.accel_bias_z      <= BIAS_W'(r_mean[2]);
            r_out_data.gyro_bias_x       <= BIAS_W'(r_mean[3]);
            r_out_data.gyro_bias_y       <= BIAS_W'(r_mean[4]);
            r_out_data.gyro_bias_z       <= BIAS_W'(r_mean[5]);
            r_out_data.valid_count       <= COUNT_W'(r_valid_cnt);
            r_out_data.success           <= success;
            r_out_data.magnitude_warning <= r_warn;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ---------------- checks ----------------
    a_valid_le_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid_cnt <= r_sample_cnt)
        else $error("valid counter ran ahead of sample counter");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("ready stayed high after an accepted beat");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_sample_cnt == '0 && r_valid_cnt == '0))
        else $error("run counters not cleared after result load");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_valid_cnt != '0))
        else $error("division started with zero count");

endmodule
